// ----- design/dqp_pkg.sv -----
// ----------------------------------------------------------------------------
// dqp_pkg
// Shared types and codes for the DNS question section parser.
// ----------------------------------------------------------------------------
package dqp_pkg;

  // parser phases
  localparam logic [2:0] PH_IDLE      = 3'd0;
  localparam logic [2:0] PH_HEADER    = 3'd1;
  localparam logic [2:0] PH_LEN       = 3'd2;
  localparam logic [2:0] PH_LABEL     = 3'd3;
  localparam logic [2:0] PH_TYPECLASS = 3'd4;
  localparam logic [2:0] PH_DONE      = 3'd5;

  // header byte position of the last header byte
  localparam logic [3:0] HDR_LAST_POS = 4'd11;
  // bytes of type and class held before the last one arrives
  localparam logic [3:0] TC_HELD      = 4'd3;

  typedef enum logic [1:0] {
    EV_HEADER   = 2'd0,
    EV_LABEL    = 2'd1,
    EV_NAME     = 2'd2,
    EV_QUESTION = 2'd3
  } dqp_event_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       msg_start;
  } dqp_word_t;

  typedef struct packed {
    dqp_event_e  event_kind;
    logic [15:0] qd_total;
    logic [15:0] an_total;
    logic [15:0] ns_total;
    logic [15:0] ar_total;
    logic [7:0]  label_char;
    logic [7:0]  label_number;
    logic [7:0]  char_position;
    logic [7:0]  labels_in_name;
    logic [15:0] question_type;
    logic [15:0] question_class;
    logic [15:0] question_number;
  } dqp_result_t;

endpackage

// ----- design/dqp_in_stage.sv -----
// ----------------------------------------------------------------------------
// dqp_in_stage
// Input register: captures one word from the input channel.
// ----------------------------------------------------------------------------
module dqp_in_stage import dqp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  dqp_word_t in_word_i,
  input  logic      advance_i,
  output logic      word_valid_o,
  output dqp_word_t word_o
);

  logic      valid_q;
  dqp_word_t word_q;

  // a held word blocks the input only while the parse stage cannot move
  assign in_stall_o = valid_q && !advance_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      word_q <= in_word_i;
    end
  end

  assign word_valid_o = valid_q;
  assign word_o       = word_q;

endmodule

// ----- design/dqp_parse.sv -----
// ----------------------------------------------------------------------------
// dqp_parse
// Per-byte parser state and the result logic for one word.
// ----------------------------------------------------------------------------
module dqp_parse import dqp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        fire_i,
  input  dqp_word_t   word_i,
  output logic        res_valid_o,
  output dqp_result_t res_o
);

  logic [2:0]  phase_q, phase_d;
  logic [3:0]  cnt_q, cnt_d;
  logic [15:0] qd_q, qd_d;
  logic [15:0] an_q, an_d;
  logic [15:0] ns_q, ns_d;
  logic [15:0] ar_q, ar_d;
  logic [7:0]  left_q, left_d;
  logic [7:0]  cpos_q, cpos_d;
  logic [7:0]  lidx_q, lidx_d;
  logic [15:0] qidx_q, qidx_d;
  logic [23:0] tc_q, tc_d;

  logic [2:0]  ph;
  logic [7:0]  b;
  logic [3:0]  cnt_inc;
  logic [7:0]  left_dec;
  logic [15:0] qidx_inc;

  always_comb begin
    b = word_i.in_byte;
    // a start word restarts from a cleared header state
    ph     = word_i.msg_start ? PH_HEADER : phase_q;
    cnt_d  = word_i.msg_start ? 4'd0  : cnt_q;
    qd_d   = word_i.msg_start ? 16'd0 : qd_q;
    an_d   = word_i.msg_start ? 16'd0 : an_q;
    ns_d   = word_i.msg_start ? 16'd0 : ns_q;
    ar_d   = word_i.msg_start ? 16'd0 : ar_q;
    left_d = word_i.msg_start ? 8'd0  : left_q;
    cpos_d = word_i.msg_start ? 8'd0  : cpos_q;
    lidx_d = word_i.msg_start ? 8'd0  : lidx_q;
    qidx_d = word_i.msg_start ? 16'd0 : qidx_q;
    tc_d   = word_i.msg_start ? 24'd0 : tc_q;
    phase_d = ph;

    cnt_inc  = cnt_d + 4'd1;
    left_dec = left_d - 8'd1;
    qidx_inc = qidx_d + 16'd1;

    res_valid_o = 1'b0;
    res_o       = '0;

    unique case (ph)
      PH_HEADER: begin
        unique case (cnt_d[3:1])
          3'd2:    qd_d = {qd_d[7:0], b};
          3'd3:    an_d = {an_d[7:0], b};
          3'd4:    ns_d = {ns_d[7:0], b};
          3'd5:    ar_d = {ar_d[7:0], b};
          default: ;
        endcase
        cnt_d = cnt_inc;
        if (cnt_inc == HDR_LAST_POS + 4'd1) begin
          cnt_d            = 4'd0;
          res_valid_o      = 1'b1;
          res_o.event_kind = EV_HEADER;
          res_o.qd_total   = qd_d;
          res_o.an_total   = an_d;
          res_o.ns_total   = ns_d;
          res_o.ar_total   = ar_d;
          qidx_d           = 16'd0;
          lidx_d           = 8'd0;
          phase_d          = (qd_d == 16'd0) ? PH_DONE : PH_LEN;
        end
      end
      PH_LEN: begin
        if (b == 8'd0) begin
          res_valid_o           = 1'b1;
          res_o.event_kind      = EV_NAME;
          res_o.labels_in_name  = lidx_d;
          res_o.question_number = qidx_d;
          cnt_d                 = 4'd0;
          tc_d                  = 24'd0;
          phase_d               = PH_TYPECLASS;
        end else begin
          left_d  = b;
          cpos_d  = 8'd0;
          phase_d = PH_LABEL;
        end
      end
      PH_LABEL: begin
        res_valid_o           = 1'b1;
        res_o.event_kind      = EV_LABEL;
        res_o.label_char      = b;
        res_o.label_number    = lidx_d;
        res_o.char_position   = cpos_d;
        res_o.question_number = qidx_d;
        cpos_d = cpos_d + 8'd1;
        left_d = left_dec;
        if (left_dec == 8'd0) begin
          if (lidx_d != 8'hFF) begin
            lidx_d = lidx_d + 8'd1;
          end
          phase_d = PH_LEN;
        end
      end
      PH_TYPECLASS: begin
        if (cnt_d < TC_HELD) begin
          tc_d  = {tc_d[15:0], b};
          cnt_d = cnt_inc;
        end else begin
          res_valid_o           = 1'b1;
          res_o.event_kind      = EV_QUESTION;
          res_o.question_type   = tc_d[23:8];
          res_o.question_class  = {tc_d[7:0], b};
          res_o.question_number = qidx_d;
          cnt_d   = 4'd0;
          tc_d    = 24'd0;
          qidx_d  = qidx_inc;
          lidx_d  = 8'd0;
          phase_d = (qidx_inc == qd_d) ? PH_DONE : PH_LEN;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      cnt_q   <= 4'd0;
      qd_q    <= 16'd0;
      an_q    <= 16'd0;
      ns_q    <= 16'd0;
      ar_q    <= 16'd0;
      left_q  <= 8'd0;
      cpos_q  <= 8'd0;
      lidx_q  <= 8'd0;
      qidx_q  <= 16'd0;
      tc_q    <= 24'd0;
    end else if (fire_i) begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      qd_q    <= qd_d;
      an_q    <= an_d;
      ns_q    <= ns_d;
      ar_q    <= ar_d;
      left_q  <= left_d;
      cpos_q  <= cpos_d;
      lidx_q  <= lidx_d;
      qidx_q  <= qidx_d;
      tc_q    <= tc_d;
    end
  end

`ifndef ASSERT_OFF
  // while walking questions the index stays below the header count
  a_qidx_below_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_LEN || phase_q == PH_LABEL || phase_q == PH_TYPECLASS)
      |-> qidx_q < qd_q)
    else $error("question index reached the question count mid-walk");

  // header position never passes the last header byte
  a_hdr_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_HEADER |-> cnt_q <= HDR_LAST_POS)
    else $error("header position out of range");

  // type and class bytes are counted one per word
  a_tc_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && !word_i.msg_start && phase_q == PH_TYPECLASS && cnt_q < TC_HELD
      |=> cnt_q == $past(cnt_q) + 4'd1)
    else $error("type/class byte count did not advance");

  // inside a name the label index only grows
  a_lidx_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && !word_i.msg_start && phase_q == PH_LABEL |=> lidx_q >= $past(lidx_q))
    else $error("label index went backwards inside a name");
`endif

endmodule

// ----- design/dqp_out_stage.sv -----
// ----------------------------------------------------------------------------
// dqp_out_stage
// Result register for the output channel.
// ----------------------------------------------------------------------------
module dqp_out_stage import dqp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        word_valid_i,
  input  logic        res_valid_i,
  input  dqp_result_t res_i,
  output logic        advance_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output dqp_result_t res_o
);

  logic        valid_q;
  dqp_result_t res_q;

  // the register can take a new word when empty or being drained
  assign advance_o = !valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (advance_o) begin
      valid_q <= word_valid_i && res_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_o && word_valid_i && res_valid_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

// ----- design/dns_question_parser_unit.sv -----
// ----------------------------------------------------------------------------
// dns_question_parser_unit
// Byte-wide DNS header and question section parser.
//
//   channel  dir  handshake               payload
//   in       in   in_valid_i/in_stall_o   in_byte_i, msg_start_i
//   out      out  out_valid_o/out_stall_i event_kind_o .. question_number_o
//
// one word per cycle sustained while the output is not stalled; a word is
// held in the input register and, if it completes an event, its result is
// then captured in the result register, and result valid rises with it
// reset clears the parser to idle and empties both registers
// a stalled output holds its result and stalls the input only when the
// input register is also occupied
// ----------------------------------------------------------------------------
module dns_question_parser_unit import dqp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  in_byte_i,
  input  logic        msg_start_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  event_kind_o,
  output logic [15:0] qd_total_o,
  output logic [15:0] an_total_o,
  output logic [15:0] ns_total_o,
  output logic [15:0] ar_total_o,
  output logic [7:0]  label_char_o,
  output logic [7:0]  label_number_o,
  output logic [7:0]  char_position_o,
  output logic [7:0]  labels_in_name_o,
  output logic [15:0] question_type_o,
  output logic [15:0] question_class_o,
  output logic [15:0] question_number_o
);

  dqp_word_t   in_word;
  dqp_word_t   word;
  logic        word_valid;
  logic        advance;
  logic        res_valid;
  dqp_result_t res;
  dqp_result_t res_out;

  assign in_word.in_byte   = in_byte_i;
  assign in_word.msg_start = msg_start_i;

  dqp_in_stage u_in (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_word_i    (in_word),
    .advance_i    (advance),
    .word_valid_o (word_valid),
    .word_o       (word)
  );

  dqp_parse u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (word_valid && advance),
    .word_i      (word),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  dqp_out_stage u_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .word_valid_i (word_valid),
    .res_valid_i  (res_valid),
    .res_i        (res),
    .advance_o    (advance),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .res_o        (res_out)
  );

  assign event_kind_o      = res_out.event_kind;
  assign qd_total_o        = res_out.qd_total;
  assign an_total_o        = res_out.an_total;
  assign ns_total_o        = res_out.ns_total;
  assign ar_total_o        = res_out.ar_total;
  assign label_char_o      = res_out.label_char;
  assign label_number_o    = res_out.label_number;
  assign char_position_o   = res_out.char_position;
  assign labels_in_name_o  = res_out.labels_in_name;
  assign question_type_o   = res_out.question_type;
  assign question_class_o  = res_out.question_class;
  assign question_number_o = res_out.question_number;

endmodule
